FILE: hw/rtl/chs_pkg.sv
package chs_pkg;

	// Table geometry.
	localparam int BUCKETS    = 7;
	localparam int POOL_NODES = 64;

	// Field widths fixed by the item format.
	localparam int KEY_W = 31;

	// Derived widths.
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int CNT_W  = $clog2(POOL_NODES + 1);

	// The key is reduced modulo BUCKETS one byte per cycle, most significant first.
	localparam int DIGIT_W    = 8;
	localparam int HASH_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W      = HASH_STEPS * DIGIT_W;
	localparam int STEP_CNT_W = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
	localparam int STEP_W     = BKT_W + DIGIT_W;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [BKT_W-1:0]  bkt_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// One digit of the modulo reduction: returns ({r, d}) mod BUCKETS.
	// Because r < BUCKETS, the value is below BUCKETS * 2^DIGIT_W, so one
	// conditional subtract of BUCKETS << k for each k leaves the remainder.
	function automatic bkt_t mod_step(input bkt_t r, input logic [DIGIT_W-1:0] d);
		logic [STEP_W-1:0] v;
		logic [STEP_W-1:0] m;
		v = {r, d};
		for (int k = DIGIT_W - 1; k >= 0; k--) begin
			m = STEP_W'(BUCKETS) << k;
			if (v >= m) begin
				v = v - m;
			end
		end
		return v[BKT_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/chs_if.sv
interface chs_in_if;
	import chs_pkg::*;

	logic valid;
	logic ready;
	logic op;
	key_t key_value;

	modport source (output valid, output op, output key_value, input ready);
	modport sink (input valid, input op, input key_value, output ready);
endinterface

interface chs_out_if;
	import chs_pkg::*;

	logic valid;
	logic ready;
	logic found;
	logic full_res;

	modport source (output valid, output found, output full_res, input ready);
	modport sink (input valid, input found, input full_res, output ready);
endinterface

FILE: hw/rtl/chs_ram.sv
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/chained_hash_set.sv
// Chained hash set. Each transfer on req either inserts key_value (op = 0) or
// searches for it (op = 1), and each produces exactly one transfer on rsp.
// Keys are spread over BUCKETS chains by key modulo BUCKETS; all chains share
// a pool of POOL_NODES nodes that are handed out in order and never freed, so
// an insert into a full pool answers full_res = 1 and changes nothing.
// Duplicate keys are kept. The remainder is computed by one shared
// reduction unit that consumes one byte of the key per cycle. An insert
// then updates the chain in S_DISP and loads the result register in S_OUT,
// which waits while an earlier result is not yet taken. A search walks its
// chain in S_WALK, if it has nodes, before S_OUT; the walk reads one node of
// the pool memory per cycle. The block takes one item at a time; req.ready is
// high only while no item is in work, but a finished result waiting in the
// output register does not hold off the next transfer. Reset empties every
// chain at once; no clearing pass is needed.
module chained_hash_set (
	input logic       clk,
	input logic       arst_n,
	chs_in_if.sink    req,
	chs_out_if.source rsp
);
	import chs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]            state_q;
	logic                  op_q;
	key_t                  key_q;
	logic [STEP_CNT_W-1:0] step_q;
	bkt_t                  bucket_q;
	node_t                 cur_q;
	cnt_t                  nodes_used_q;
	logic                  res_found_q;
	logic                  res_full_q;

	// Per-bucket chain ends. Only the head valid bits need a reset.
	node_t                 head_q [BUCKETS];
	node_t                 tail_q [BUCKETS];
	logic [BUCKETS-1:0]    head_valid_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_found_q;
	logic                  out_full_q;

	logic [PAD_W-1:0]      key_pad;
	logic [DIGIT_W-1:0]    digit;
	logic                  pool_full;
	logic                  hv;
	node_t                 head_sel;
	node_t                 tail_sel;
	node_t                 new_node;
	node_t                 rd_addr;
	key_t                  key_rd;
	node_t                 link_rd;
	logic                  key_we;
	logic                  link_we;
	logic                  out_free;

	assign key_pad = PAD_W'(key_q);
	// Digits are taken most significant first.
	assign digit = key_pad[(HASH_STEPS - 1 - int'(step_q)) * DIGIT_W +: DIGIT_W];

	assign pool_full = (nodes_used_q == CNT_W'(POOL_NODES));
	assign hv        = head_valid_q[bucket_q];
	assign head_sel  = head_q[bucket_q];
	assign tail_sel  = tail_q[bucket_q];
	assign new_node  = nodes_used_q[NODE_W-1:0];

	// An accepted insert writes its key into the next free node and, when the
	// chain already has nodes, links the old tail to the new node.
	assign key_we  = (state_q == S_DISP) && (op_q == OP_INSERT) && !pool_full;
	assign link_we = key_we && hv;

	// The walk chases links straight from the memory output, so each cycle
	// in the walk compares one node and fetches the next.
	assign rd_addr = (state_q == S_WALK) ? link_rd : head_sel;

	chs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (POOL_NODES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (new_node),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	chs_ram #(
		.WIDTH (NODE_W),
		.DEPTH (POOL_NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (tail_sel),
		.wdata (new_node),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	assign req.ready = (state_q == S_IDLE);

	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.found    = out_found_q;
	assign rsp.full_res = out_full_q;

	// Sequencer and chain bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nodes_used_q <= '0;
			head_valid_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (step_q == STEP_CNT_W'(HASH_STEPS - 1)) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (op_q == OP_INSERT) begin
						if (!pool_full) begin
							nodes_used_q <= nodes_used_q + 1'b1;
							head_valid_q[bucket_q] <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (hv) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_WALK: begin
					// The chain ends at the bucket's tail node.
					if ((key_rd == key_q) || (cur_q == tail_sel)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				key_q    <= req.key_value;
				step_q   <= '0;
				bucket_q <= '0;
			end
			S_HASH: begin
				bucket_q <= mod_step(bucket_q, digit);
				step_q   <= step_q + 1'b1;
			end
			S_DISP: begin
				cur_q       <= head_sel;
				res_found_q <= 1'b0;
				res_full_q  <= (op_q == OP_INSERT) && pool_full;
				if (key_we) begin
					if (!hv) begin
						head_q[bucket_q] <= new_node;
					end
					tail_q[bucket_q] <= new_node;
				end
			end
			S_WALK: begin
				cur_q <= link_rd;
				if (key_rd == key_q) begin
					res_found_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
	end
endmodule

FILE: hw/rtl/chs_checker.sv
module chs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_found,
	input logic rsp_full_res
);
	import chs_pkg::*;

	// One item at a time: after a transfer in, the input side closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("input accepted while an item was in work");

	// A result is never both a hit and a refusal.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_full_res))
	else $error("result flags both found and full");

	// A waiting result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
	else $error("result withdrawn before transfer");

	// A waiting result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_full_res))
	else $error("result changed before transfer");
endmodule

bind chained_hash_set chs_checker u_chs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_found    (rsp.found),
	.rsp_full_res (rsp.full_res)
);
